// File: rtl/ddof_pkg.sv
// Shared types and constants for the odometry fusion block.
package ddof_pkg;

   // Operand selection for the shared multiplier
   typedef enum logic [2:0] {
      MUL_TURN,
      MUL_GYRO,
      MUL_RECIP,
      MUL_QBACK,
      MUL_ERR,
      MUL_X,
      MUL_Y
   } mul_sel_type;

   // Register indexes on the CSR port
   localparam logic CSR_TURN_GAIN    = 1'b0;
   localparam logic CSR_BLEND_WEIGHT = 1'b1;

   localparam logic [19:0] TURN_GAIN_RST    = 20'd69570;
   localparam logic [16:0] BLEND_WEIGHT_RST = 17'd3277;
   localparam logic [16:0] BLEND_WEIGHT_MAX = 17'd65536;

   // Gyro scale: 1/256 angle unit per second times microseconds.
   // Divisor 256e6 = 2^14 * 15625; the odd part uses the reciprocal 2^47/15625.
   localparam logic [51:0]        GYRO_HALF  = 52'd128000000;
   localparam logic signed [34:0] GYRO_ODD   = 35'sd15625;
   localparam logic signed [34:0] GYRO_RECIP = 35'sd9007199254;

   // CORDIC gain-compensated start value, Q30
   localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
   localparam int CORDIC_MAX = 24;

   // atan(2^-i) in 2^32 units per turn
   localparam logic [31:0] ATAN_TAB [CORDIC_MAX] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Commands from controller to datapath
   typedef struct packed {
      logic        load_in;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        enc_upd;
      logic        div_init;
      logic        div_est;
      logic        div_fix;
      logic        pred_upd;
      logic        fuse_upd;
      logic        fuse_copy;
      logic        cord_init;
      logic        cord_step;
      logic        px_upd;
      logic        py_upd;
      logic        commit;
      logic [4:0]  step_idx;
   } ddof_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic imu;
   } ddof_sts_type;

endpackage

// File: rtl/diff_drive_odometry_fusion.sv
// Top level of the differential-drive odometry and yaw fusion block.
//
// One request item carries both wheel travels, the gyro rate, the time step
// and the IMU-valid flag (tuser). Each request gives exactly one response
// item with the new pose, fused and encoder-only heading and mean travel.
// Items are processed one at a time. With imu_ok set an item passes through
// the gyro division (shift, reciprocal multiply and one correction) and the
// iterative CORDIC, with CORDIC_STEPS capped at 24; without IMU the division
// and fusion are skipped. The next item can be accepted in the same cycle
// as the result appears. All products share one 32x35 multiplier.
// A finished result sits in the response register while the next item is
// accepted and processed; if the receiver still stalls when that next item
// is done, the block waits and holds its pose until the response is taken.
// Synchronous reset clears pose and headings to zero, loads the register
// defaults and drops rsp_tvalid. CSR writes take effect at once; the user
// must make them only while the block is idle; the block does not enforce it.
module diff_drive_odometry_fusion import ddof_pkg::*; #(
   parameter int CORDIC_STEPS = 16,
   parameter int ANGLE_BITS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dist_left[23:0], dist_right[47:24], gyro_rate[79:48], step_us[99:80]
   input  logic [103:0] req_tdata,
   // imu_ok[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x[31:0], pos_y[63:32], heading[79:64], heading_enc[95:80],
   // step_dist[119:96]
   output logic [119:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [19:0]  csr_wdata
);

   localparam int NSTEP = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;

   ddof_cmd_type       cmd;
   ddof_sts_type       sts;
   logic signed [31:0] pos_x, pos_y;
   logic signed [15:0] heading, heading_enc;
   logic signed [23:0] step_dist;

   ddof_ctrl #(.NSTEP(NSTEP)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ddof_dp #(.AB(ANGLE_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .dist_left   ($signed(req_tdata[23:0])),
      .dist_right  ($signed(req_tdata[47:24])),
      .gyro_rate   ($signed(req_tdata[79:48])),
      .step_us     (req_tdata[99:80]),
      .imu_ok      (req_tuser),
      .pos_x       (pos_x),
      .pos_y       (pos_y),
      .heading     (heading),
      .heading_enc (heading_enc),
      .step_dist   (step_dist)
   );

   assign rsp_tdata = {step_dist, heading_enc, heading, pos_y, pos_x};

endmodule

// File: rtl/ddof_ctrl.sv
// Sequencing state machine for the odometry fusion block.
module ddof_ctrl import ddof_pkg::*; #(
   parameter int NSTEP = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  ddof_sts_type sts,
   output ddof_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_MTURN, S_ENC, S_DIVI, S_DIV, S_QEST, S_QFIX, S_PRED, S_MERR,
      S_FUSE, S_NOIMU, S_MID, S_CORD, S_MX, S_MY, S_PY, S_DONE
   } state_type;

   localparam logic [4:0] CORD_LAST = 5'(NSTEP - 1);

   state_type  state_ff;
   logic [4:0] cnt_ff;
   logic       valid_ff;
   logic       out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   // Command decode
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_TURN;
      cmd.step_idx = cnt_ff;
      case (state_ff)
         S_IDLE:  cmd.load_in = req_tvalid;
         S_MTURN: cmd.mul_en = 1'b1;
         S_ENC: begin
            cmd.enc_upd = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_GYRO;
         end
         S_DIVI:  cmd.div_init = 1'b1;
         S_DIV: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RECIP;
         end
         S_QEST: begin
            cmd.div_est = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_QBACK;
         end
         S_QFIX:  cmd.div_fix = 1'b1;
         S_PRED:  cmd.pred_upd = 1'b1;
         S_MERR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR;
         end
         S_FUSE:  cmd.fuse_upd = 1'b1;
         S_NOIMU: cmd.fuse_copy = 1'b1;
         S_MID:   cmd.cord_init = 1'b1;
         S_CORD:  cmd.cord_step = 1'b1;
         S_MX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_X;
         end
         S_MY: begin
            cmd.px_upd  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_Y;
         end
         S_PY:    cmd.py_upd = 1'b1;
         S_DONE:  cmd.commit = out_free;
         default: cmd = '0;
      endcase
   end

   // State, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && out_free) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE:  if (req_tvalid) state_ff <= S_MTURN;
            S_MTURN: state_ff <= S_ENC;
            S_ENC:   state_ff <= sts.imu ? S_DIVI : S_NOIMU;
            S_DIVI:  state_ff <= S_DIV;
            S_DIV:   state_ff <= S_QEST;
            S_QEST:  state_ff <= S_QFIX;
            S_QFIX:  state_ff <= S_PRED;
            S_PRED:  state_ff <= S_MERR;
            S_MERR:  state_ff <= S_FUSE;
            S_FUSE:  state_ff <= S_MID;
            S_NOIMU: state_ff <= S_MID;
            S_MID: begin
               cnt_ff   <= '0;
               state_ff <= S_CORD;
            end
            S_CORD: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == CORD_LAST) state_ff <= S_MX;
            end
            S_MX:    state_ff <= S_MY;
            S_MY:    state_ff <= S_PY;
            S_PY:    state_ff <= S_DONE;
            S_DONE:  if (out_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/ddof_dp.sv
// Datapath: shared multiplier, gyro divider, CORDIC and pose registers.
module ddof_dp import ddof_pkg::*; #(
   parameter int AB = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  ddof_cmd_type        cmd,
   output ddof_sts_type        sts,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [19:0]         csr_wdata,
   input  logic signed [23:0]  dist_left,
   input  logic signed [23:0]  dist_right,
   input  logic signed [31:0]  gyro_rate,
   input  logic [19:0]         step_us,
   input  logic                imu_ok,
   output logic signed [31:0]  pos_x,
   output logic signed [31:0]  pos_y,
   output logic signed [15:0]  heading,
   output logic signed [15:0]  heading_enc,
   output logic signed [23:0]  step_dist
);

   localparam int SH = 32 - AB;
   localparam logic [66:0] HALF_TURN = 67'(1) << (SH - 1);
   localparam logic [66:0] HALF_ERR  = 67'(1) << 15;
   localparam logic [66:0] HALF_POS  = 67'(1) << 29;

   logic [19:0]        tg_ff;
   logic [16:0]        bw_ff;
   logic signed [31:0] g_ff;
   logic [19:0]        t_ff;
   logic               imu_ff;
   logic signed [23:0] ds_ff;
   logic signed [24:0] dw_ff;
   logic signed [66:0] prod_ff;
   logic [AB-1:0]      enc_ff, pred_ff, fused_ff;
   logic [37:0]        dn_ff;
   logic [24:0]        q_ff;
   logic               gneg_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               flip_ff;
   logic [31:0]        px_ff, py_ff;
   logic [31:0]        pose_x_ff, pose_y_ff;
   logic [AB-1:0]      yaw_f_ff, yaw_e_ff;
   logic signed [23:0] ds_out_ff;

   logic signed [24:0] sum_in;
   logic signed [31:0] ma;
   logic signed [34:0] mb;
   logic signed [34:0] c_val, s_val;
   logic [66:0]        r_turn, r_err, r_pos;
   logic [66:0]        mag;
   logic [51:0]        nsum;
   logic [15:0]        rem_lo;
   logic [AB-1:0]      inc, err, diff, mid;
   logic [31:0]        u_ang, a_ang;
   logic               flip;
   logic signed [33:0] dx, dy, at;

   assign sts.imu = imu_ff;
   assign sum_in  = 25'(dist_left) + 25'(dist_right);

   // CORDIC outputs with half-turn correction
   assign c_val = flip_ff ? -35'(x_ff) : 35'(x_ff);
   assign s_val = flip_ff ? -35'(y_ff) : 35'(y_ff);

   // Multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_TURN: begin
            ma = 32'(dw_ff);
            mb = $signed({15'b0, tg_ff});
         end
         MUL_GYRO: begin
            ma = g_ff;
            mb = $signed({15'b0, t_ff});
         end
         MUL_RECIP: begin
            ma = $signed({1'b0, dn_ff[37:7]});
            mb = GYRO_RECIP;
         end
         MUL_QBACK: begin
            ma = $signed({7'b0, prod_ff[64:40]});
            mb = GYRO_ODD;
         end
         MUL_ERR: begin
            ma = 32'($signed(err));
            mb = $signed({18'b0, bw_ff});
         end
         MUL_X: begin
            ma = 32'(ds_ff);
            mb = c_val;
         end
         MUL_Y: begin
            ma = 32'(ds_ff);
            mb = s_val;
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   // Rounded products and intermediate angles
   always_comb begin
      r_turn = prod_ff + HALF_TURN;
      r_err  = prod_ff + HALF_ERR;
      r_pos  = prod_ff + HALF_POS;
      mag    = prod_ff[66] ? -prod_ff : prod_ff;
      nsum   = mag[51:0] + GYRO_HALF;
      rem_lo = dn_ff[15:0] - prod_ff[15:0];
      inc    = gneg_ff ? -q_ff[AB-1:0] : q_ff[AB-1:0];
      err    = enc_ff - pred_ff;
      diff   = fused_ff - yaw_f_ff;
      mid    = yaw_f_ff + AB'($signed(diff) >>> 1);
      u_ang  = {mid, {SH{1'b0}}};
      flip   = ($signed(u_ang) > 32'sh40000000) || ($signed(u_ang) < -32'sh40000000);
      a_ang  = flip ? (u_ang ^ 32'h80000000) : u_ang;
      dx     = y_ff >>> cmd.step_idx;
      dy     = x_ff >>> cmd.step_idx;
      at     = 34'(ATAN_TAB[cmd.step_idx]);
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tg_ff <= TURN_GAIN_RST;
         bw_ff <= BLEND_WEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TURN_GAIN:    tg_ff <= csr_wdata;
            CSR_BLEND_WEIGHT: bw_ff <= (csr_wdata[16:0] > BLEND_WEIGHT_MAX) ?
                                       BLEND_WEIGHT_MAX : csr_wdata[16:0];
            default:          tg_ff <= tg_ff;
         endcase
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         g_ff   <= gyro_rate;
         t_ff   <= step_us;
         imu_ff <= imu_ok;
         ds_ff  <= sum_in[24:1];
         dw_ff  <= 25'(dist_right) - 25'(dist_left);
      end
      if (cmd.mul_en) prod_ff <= ma * mb;
      if (cmd.enc_upd) enc_ff <= yaw_e_ff + r_turn[31:SH];
      // gyro increment: rounded magnitude shifted by 14, then times 2^47/15625;
      // the estimate is at most one low and one compare fixes it
      if (cmd.div_init) begin
         dn_ff   <= nsum[51:14];
         gneg_ff <= prod_ff[66];
      end
      if (cmd.div_est) q_ff <= prod_ff[64:40];
      if (cmd.div_fix && (rem_lo >= 16'(GYRO_ODD))) q_ff <= q_ff + 25'd1;
      if (cmd.pred_upd) pred_ff <= yaw_f_ff + inc;
      if (cmd.fuse_upd) fused_ff <= pred_ff + r_err[15+AB:16];
      if (cmd.fuse_copy) fused_ff <= enc_ff;
      // CORDIC rotation on the mid-arc heading
      if (cmd.cord_init) begin
         flip_ff <= flip;
         x_ff    <= CORDIC_K;
         y_ff    <= '0;
         z_ff    <= 34'($signed(a_ang));
      end
      if (cmd.cord_step) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
      end
      if (cmd.px_upd) px_ff <= pose_x_ff + r_pos[61:30];
      if (cmd.py_upd) py_ff <= pose_y_ff + r_pos[61:30];
   end

   // Pose state, doubles as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         yaw_f_ff  <= '0;
         yaw_e_ff  <= '0;
         ds_out_ff <= '0;
      end else if (cmd.commit) begin
         pose_x_ff <= px_ff;
         pose_y_ff <= py_ff;
         yaw_f_ff  <= fused_ff;
         yaw_e_ff  <= enc_ff;
         ds_out_ff <= ds_ff;
      end
   end

   assign pos_x     = pose_x_ff;
   assign pos_y     = pose_y_ff;
   assign step_dist = ds_out_ff;

   // Scale angles to 16 bits
   generate
      if (AB >= 16) begin : g_hd_down
         assign heading     = yaw_f_ff[AB-1 -: 16];
         assign heading_enc = yaw_e_ff[AB-1 -: 16];
      end else begin : g_hd_up
         assign heading     = {yaw_f_ff, {(16-AB){1'b0}}};
         assign heading_enc = {yaw_e_ff, {(16-AB){1'b0}}};
      end
   endgenerate

endmodule

// File: rtl/ddof_checker.sv
// Port-level checks for the odometry fusion block, bound to the top level.
module ddof_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [103:0] req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic         csr_we,
   input logic         csr_index,
   input logic [19:0]  csr_wdata
);

   // No result pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // One item in flight: intake closes after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready stayed high after accept");

   // A new result only appears after an item was being worked on
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without work");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind diff_drive_odometry_fusion ddof_checker u_ddof_checker (.*);
